// ===== src/tvfs_pkg.sv =====
`default_nettype none
package tvfs_pkg;

    localparam int GRID_DIM_DEF = 32;

    localparam int CMD_W   = 1;
    localparam int CELL_W  = 5;
    localparam int VEC_W   = 16;
    localparam int POS_W   = 18;
    localparam int DIM_W   = 6;
    localparam int WGT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W = 3 * VEC_W;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 6'd2;
    localparam logic [16:0]      POS_ONE   = 17'h10000;

    // a + (b - a) * w / 2^16, rounded half up
    function automatic logic signed [VEC_W-1:0] lerp(
        input logic signed [VEC_W-1:0] a,
        input logic signed [VEC_W-1:0] b,
        input logic [WGT_W-1:0] w
    );
        logic signed [VEC_W:0]   d;
        logic signed [VEC_W+WGT_W+1:0] t;
        logic signed [VEC_W:0]   q;
        logic signed [VEC_W:0]   r;
        d = {b[VEC_W-1], b} - {a[VEC_W-1], a};
        t = d * $signed({1'b0, w});
        t = t + (VEC_W+WGT_W+2)'(32768);
        q = t[VEC_W+WGT_W:WGT_W];
        r = {a[VEC_W-1], a} + q;
        return r[VEC_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/tvfs_req_if.sv =====
`default_nettype none
interface tvfs_req_if;
    logic valid;
    logic ready;
    logic [tvfs_pkg::CMD_W-1:0]         cmd;
    logic [tvfs_pkg::CELL_W-1:0]        cell_x;
    logic [tvfs_pkg::CELL_W-1:0]        cell_y;
    logic [tvfs_pkg::CELL_W-1:0]        cell_z;
    logic signed [tvfs_pkg::VEC_W-1:0]  vec_x;
    logic signed [tvfs_pkg::VEC_W-1:0]  vec_y;
    logic signed [tvfs_pkg::VEC_W-1:0]  vec_z;
    logic signed [tvfs_pkg::POS_W-1:0]  pos_x;
    logic signed [tvfs_pkg::POS_W-1:0]  pos_y;
    logic signed [tvfs_pkg::POS_W-1:0]  pos_z;

    modport source (output valid, cmd, cell_x, cell_y, cell_z, vec_x, vec_y, vec_z,
                    pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, cmd, cell_x, cell_y, cell_z, vec_x, vec_y, vec_z,
                  pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

// ===== src/tvfs_rsp_if.sv =====
`default_nettype none
interface tvfs_rsp_if;
    logic valid;
    logic ready;
    logic signed [tvfs_pkg::VEC_W-1:0] out_x;
    logic signed [tvfs_pkg::VEC_W-1:0] out_y;
    logic signed [tvfs_pkg::VEC_W-1:0] out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

// ===== src/tvfs_cfg_if.sv =====
`default_nettype none
interface tvfs_cfg_if;
    logic valid;
    logic ready;
    logic [tvfs_pkg::CFG_IDX_W-1:0] index;
    logic [tvfs_pkg::DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/trilinear_vector_field_sampler_core.sv =====
// sample results reach rsp via the stage 1, bank read and x, y, z lerp registers
// one item per cycle unless rsp stalls; eight parity banks give eight corners in one read
// write items pass the same pipe and take effect at stage two, before any later read
// rst_n clears the valid bits and sets dim_x, dim_y, dim_z to 2
// grid contents are not cleared and are undefined until written
`default_nettype none
module trilinear_vector_field_sampler_core #(
    parameter int GRID_DIM = tvfs_pkg::GRID_DIM_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tvfs_req_if.sink   req,
    tvfs_rsp_if.source rsp,
    tvfs_cfg_if.sink   cfg
);
    localparam int CW = $clog2(GRID_DIM);
    localparam int WW = tvfs_pkg::WGT_W;

    logic [tvfs_pkg::DIM_W-1:0] dim_x_reg;
    logic [tvfs_pkg::DIM_W-1:0] dim_y_reg;
    logic [tvfs_pkg::DIM_W-1:0] dim_z_reg;

    logic adv;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v5_reg;

    logic [CW-1:0] x0;
    logic [CW-1:0] x1;
    logic [CW-1:0] y0;
    logic [CW-1:0] y1;
    logic [CW-1:0] z0;
    logic [CW-1:0] z1;
    logic [WW-1:0] wx;
    logic [WW-1:0] wy;
    logic [WW-1:0] wz;

    logic [tvfs_pkg::CMD_W-1:0]    cmd1_reg;
    logic [tvfs_pkg::CELL_W-1:0]   cx1_reg;
    logic [tvfs_pkg::CELL_W-1:0]   cy1_reg;
    logic [tvfs_pkg::CELL_W-1:0]   cz1_reg;
    logic [tvfs_pkg::ENTRY_W-1:0]  vec1_reg;
    logic [CW-1:0] x0_reg;
    logic [CW-1:0] x1_reg;
    logic [CW-1:0] y0_reg;
    logic [CW-1:0] y1_reg;
    logic [CW-1:0] z0_reg;
    logic [CW-1:0] z1_reg;
    logic [WW-1:0] wx1_reg;
    logic [WW-1:0] wy1_reg;
    logic [WW-1:0] wz1_reg;
    logic [WW-1:0] wx2_reg;
    logic [WW-1:0] wy2_reg;
    logic [WW-1:0] wz2_reg;

    logic wr_en;
    logic in_range;
    logic [tvfs_pkg::ENTRY_W-1:0] corner [8];
    logic signed [tvfs_pkg::VEC_W-1:0] res [3];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= tvfs_pkg::DIM_RESET;
            dim_y_reg <= tvfs_pkg::DIM_RESET;
            dim_z_reg <= tvfs_pkg::DIM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tvfs_pkg::CFG_DIM_X: dim_x_reg <= cfg.data;
                tvfs_pkg::CFG_DIM_Y: dim_y_reg <= cfg.data;
                tvfs_pkg::CFG_DIM_Z: dim_z_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // stage 1: clamp, scale and split each coordinate
    tvfs_axis #(.GRID_DIM(GRID_DIM)) u_axis_x (
        .pos(req.pos_x), .dim(dim_x_reg), .lo(x0), .hi(x1), .wgt(wx));
    tvfs_axis #(.GRID_DIM(GRID_DIM)) u_axis_y (
        .pos(req.pos_y), .dim(dim_y_reg), .lo(y0), .hi(y1), .wgt(wy));
    tvfs_axis #(.GRID_DIM(GRID_DIM)) u_axis_z (
        .pos(req.pos_z), .dim(dim_z_reg), .lo(z0), .hi(z1), .wgt(wz));

    assign adv       = !v5_reg || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg && (cmd1_reg == tvfs_pkg::CMD_SAMPLE);
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= req.cmd;
            cx1_reg  <= req.cell_x;
            cy1_reg  <= req.cell_y;
            cz1_reg  <= req.cell_z;
            vec1_reg <= {req.vec_z, req.vec_y, req.vec_x};
            x0_reg   <= x0;
            x1_reg   <= x1;
            y0_reg   <= y0;
            y1_reg   <= y1;
            z0_reg   <= z0;
            z1_reg   <= z1;
            wx1_reg  <= wx;
            wy1_reg  <= wy;
            wz1_reg  <= wz;
            wx2_reg  <= wx1_reg;
            wy2_reg  <= wy1_reg;
            wz2_reg  <= wz1_reg;
        end
    end

    // stage 2: bank write or eight-corner read
    assign in_range = ({3'b000, cx1_reg} < 8'(GRID_DIM))
                   && ({3'b000, cy1_reg} < 8'(GRID_DIM))
                   && ({3'b000, cz1_reg} < 8'(GRID_DIM));
    assign wr_en = adv && v1_reg && (cmd1_reg == tvfs_pkg::CMD_WRITE) && in_range;

    tvfs_fetch #(.GRID_DIM(GRID_DIM)) u_fetch (
        .clk    (clk),
        .adv    (adv),
        .wr_en  (wr_en),
        .wr_x   (CW'(cx1_reg)),
        .wr_y   (CW'(cy1_reg)),
        .wr_z   (CW'(cz1_reg)),
        .wr_data(vec1_reg),
        .x0     (x0_reg),
        .x1     (x1_reg),
        .y0     (y0_reg),
        .y1     (y1_reg),
        .z0     (z0_reg),
        .z1     (z1_reg),
        .corner (corner)
    );

    // stages 3 to 5: lerp along x, y, z
    tvfs_blend u_blend (
        .clk   (clk),
        .adv   (adv),
        .corner(corner),
        .wx    (wx2_reg),
        .wy    (wy2_reg),
        .wz    (wz2_reg),
        .res   (res)
    );

    assign rsp.valid = v5_reg;
    assign rsp.out_x = res[0];
    assign rsp.out_y = res[1];
    assign rsp.out_z = res[2];
endmodule
`default_nettype wire

// ===== src/tvfs_ram.sv =====
`default_nettype none
module tvfs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== src/tvfs_axis.sv =====
`default_nettype none
module tvfs_axis #(
    parameter int GRID_DIM = tvfs_pkg::GRID_DIM_DEF,
    localparam int CW = $clog2(GRID_DIM)
) (
    input  wire logic signed [tvfs_pkg::POS_W-1:0] pos,
    input  wire logic [tvfs_pkg::DIM_W-1:0]        dim,
    output logic [CW-1:0]                          lo,
    output logic [CW-1:0]                          hi,
    output logic [tvfs_pkg::WGT_W-1:0]             wgt
);
    logic [7:0]     deff;
    logic [CW-1:0]  maxi;
    logic [16:0]    p;
    logic [16+CW:0] scaled;
    logic [CW:0]    ip;

    always_comb
    begin
        priority if (dim < 6'd2)
            deff = 8'd2;
        else if ({2'b00, dim} > 8'(GRID_DIM))
            deff = 8'(GRID_DIM);
        else
            deff = {2'b00, dim};
        maxi = CW'(deff - 8'd1);

        priority if (pos[tvfs_pkg::POS_W-1])
            p = '0;
        else if (pos > $signed({1'b0, tvfs_pkg::POS_ONE}))
            p = tvfs_pkg::POS_ONE;
        else
            p = pos[16:0];

        scaled = (17+CW)'(p) * (17+CW)'(maxi);
        ip     = scaled[16+CW:16];
        lo     = (ip > {1'b0, maxi}) ? maxi : ip[CW-1:0];
        hi     = (lo == maxi) ? maxi : lo + CW'(1);
        wgt    = scaled[15:0];
    end
endmodule
`default_nettype wire

// ===== src/tvfs_fetch.sv =====
`default_nettype none
module tvfs_fetch #(
    parameter int GRID_DIM = tvfs_pkg::GRID_DIM_DEF,
    localparam int CW = $clog2(GRID_DIM)
) (
    input  wire logic                          clk,
    input  wire logic                          adv,
    input  wire logic                          wr_en,
    input  wire logic [CW-1:0]                 wr_x,
    input  wire logic [CW-1:0]                 wr_y,
    input  wire logic [CW-1:0]                 wr_z,
    input  wire logic [tvfs_pkg::ENTRY_W-1:0]  wr_data,
    input  wire logic [CW-1:0]                 x0,
    input  wire logic [CW-1:0]                 x1,
    input  wire logic [CW-1:0]                 y0,
    input  wire logic [CW-1:0]                 y1,
    input  wire logic [CW-1:0]                 z0,
    input  wire logic [CW-1:0]                 z1,
    output logic [tvfs_pkg::ENTRY_W-1:0]       corner [8]
);
    localparam int HALF  = (GRID_DIM + 1) / 2;
    localparam int DEPTH = HALF * HALF * HALF;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [AW-1:0] bank_addr(
        input logic [CW-1:0] x,
        input logic [CW-1:0] y,
        input logic [CW-1:0] z
    );
        logic [CW-1:0] xh;
        logic [CW-1:0] yh;
        logic [CW-1:0] zh;
        xh = x >> 1;
        yh = y >> 1;
        zh = z >> 1;
        return AW'((int'(zh) * HALF + int'(yh)) * HALF + int'(xh));
    endfunction

    logic [tvfs_pkg::ENTRY_W-1:0] rd [8];
    logic [1:0] xs_reg;
    logic [1:0] ys_reg;
    logic [1:0] zs_reg;
    logic [2:0] wbank;
    logic [AW-1:0] waddr;

    assign wbank = {wr_z[0], wr_y[0], wr_x[0]};
    assign waddr = bank_addr(wr_x, wr_y, wr_z);

    for (genvar b = 0; b < 8; b++)
    begin : g_bank
        localparam logic [2:0] BID = 3'(b);
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] az;
        assign ax = (x0[0] == BID[0]) ? x0 : x1;
        assign ay = (y0[0] == BID[1]) ? y0 : y1;
        assign az = (z0[0] == BID[2]) ? z0 : z1;

        tvfs_ram #(
            .WIDTH(tvfs_pkg::ENTRY_W),
            .DEPTH(DEPTH)
        ) u_ram (
            .clk  (clk),
            .we   (wr_en && (wbank == BID)),
            .waddr(waddr),
            .wdata(wr_data),
            .re   (adv),
            .raddr(bank_addr(ax, ay, az)),
            .rdata(rd[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xs_reg <= {x1[0], x0[0]};
            ys_reg <= {y1[0], y0[0]};
            zs_reg <= {z1[0], z0[0]};
        end
    end

    // corner k is {z, y, x} upper-corner flags
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            corner[k] = rd[{zs_reg[k[2]], ys_reg[k[1]], xs_reg[k[0]]}];
        end
    end
endmodule
`default_nettype wire

// ===== src/tvfs_blend.sv =====
`default_nettype none
module tvfs_blend (
    input  wire logic                            clk,
    input  wire logic                            adv,
    input  wire logic [tvfs_pkg::ENTRY_W-1:0]    corner [8],
    input  wire logic [tvfs_pkg::WGT_W-1:0]      wx,
    input  wire logic [tvfs_pkg::WGT_W-1:0]      wy,
    input  wire logic [tvfs_pkg::WGT_W-1:0]      wz,
    output logic signed [tvfs_pkg::VEC_W-1:0]    res [3]
);
    localparam int VW = tvfs_pkg::VEC_W;

    logic signed [VW-1:0] cx_next [3][4];
    logic signed [VW-1:0] cx_reg  [3][4];
    logic signed [VW-1:0] cy_next [3][2];
    logic signed [VW-1:0] cy_reg  [3][2];
    logic signed [VW-1:0] cz_next [3];
    logic signed [VW-1:0] cz_reg  [3];
    logic [tvfs_pkg::WGT_W-1:0] wy_reg;
    logic [tvfs_pkg::WGT_W-1:0] wz_a_reg;
    logic [tvfs_pkg::WGT_W-1:0] wz_b_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                cx_next[c][j] = tvfs_pkg::lerp(corner[2*j][c*VW +: VW],
                                               corner[2*j+1][c*VW +: VW], wx);
            end
            for (int j = 0; j < 2; j++)
            begin
                cy_next[c][j] = tvfs_pkg::lerp(cx_reg[c][2*j], cx_reg[c][2*j+1], wy_reg);
            end
            cz_next[c] = tvfs_pkg::lerp(cy_reg[c][0], cy_reg[c][1], wz_b_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg   <= cx_next;
            wy_reg   <= wy;
            wz_a_reg <= wz;
            cy_reg   <= cy_next;
            wz_b_reg <= wz_a_reg;
            cz_reg   <= cz_next;
        end
    end

    assign res = cz_reg;
endmodule
`default_nettype wire
